>>> sv/cws_pkg.sv
`default_nettype none

package cws_pkg;

  // Fixed field widths
  localparam int unsigned EVENT_BITS   = 32;
  localparam int unsigned WINDOW_BITS  = 20;
  localparam int unsigned TYPE_BITS    = 2;
  localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 20'd4000;

  // Pairing state of the back end
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_OPEN = 2'd1,
    PH_PAIR = 2'd2,
    PH_SKIP = 2'd3
  } phase_e;

  // Coincidence classification
  typedef enum logic [TYPE_BITS-1:0] {
    PT_TRUE    = 2'd0,
    PT_SCATTER = 2'd1,
    PT_RANDOM  = 2'd2
  } pair_type_e;

  // Window register write (enable and data) as seen by the back end
  typedef struct packed {
    logic                   we;
    logic [WINDOW_BITS-1:0] window;
  } cfg_t;

  // Window end of a time; saturates when the sum overflows 64 bits
  function automatic logic [64:0] window_end(input logic [63:0] t,
                                             input logic [WINDOW_BITS-1:0] w);
    logic [64:0] sum;
    sum = {1'b0, t} + {{(65-WINDOW_BITS){1'b0}}, w};
    if (sum[64]) begin
      sum = {1'b0, {64{1'b1}}};
    end
    return sum;
  endfunction

endpackage

`default_nettype wire

>>> sv/cws_queue.sv
`default_nettype none

module cws_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output logic [WIDTH-1:0]      pop_data_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the request in the free slot
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

>>> sv/cws_front.sv
`default_nettype none

module cws_front #(
  parameter int unsigned TIME_BITS    = 48,
  parameter int unsigned CRYSTAL_BITS = 15,
  parameter int unsigned TDATA_BITS   = 96,
  parameter int unsigned ENTRY_BITS   = 145
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_wr_en_i,
  input  wire logic [cws_pkg::WINDOW_BITS-1:0]     cfg_wr_data_i,
  output cws_pkg::cfg_t                            cfg_o,
  input  wire logic                                s_valid_i,
  output logic                                     s_ready_o,
  input  wire logic [TDATA_BITS-1:0]               s_data_i,
  input  wire logic                                s_flag_i,
  output logic                                     q_valid_o,
  input  wire logic                                q_ready_i,
  output logic [ENTRY_BITS-1:0]                    q_data_o
);

  import cws_pkg::*;

  logic [WINDOW_BITS-1:0] window_q;
  logic [TIME_BITS-1:0]   arrival;
  logic [CRYSTAL_BITS-1:0] crystal;
  logic [EVENT_BITS-1:0]  event_id;
  logic [64:0]            end_full;

  // Hold the window register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RESET;
    end else if (cfg_wr_en_i) begin
      window_q <= cfg_wr_data_i;
    end
  end

  assign cfg_o.we     = cfg_wr_en_i;
  assign cfg_o.window = cfg_wr_data_i;

  // Unpack the single and tag it with its own window end
  assign arrival  = s_data_i[TIME_BITS-1:0];
  assign crystal  = s_data_i[TIME_BITS +: CRYSTAL_BITS];
  assign event_id = s_data_i[TIME_BITS+CRYSTAL_BITS +: EVENT_BITS];
  assign end_full = window_end(64'(arrival), window_q);

  assign q_valid_o = s_valid_i;
  assign s_ready_o = q_ready_i;
  assign q_data_o  = {s_flag_i, event_id, crystal, arrival, end_full[TIME_BITS:0]};

endmodule

`default_nettype wire

>>> sv/cws_back.sv
`default_nettype none

module cws_back #(
  parameter int unsigned TIME_BITS    = 48,
  parameter int unsigned CRYSTAL_BITS = 15,
  parameter int unsigned ENTRY_BITS   = 145
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  cws_pkg::cfg_t                            cfg_i,
  input  wire logic                                q_valid_i,
  output logic                                     q_ready_o,
  input  wire logic [ENTRY_BITS-1:0]               q_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [CRYSTAL_BITS-1:0]                  out_first_o,
  output logic [CRYSTAL_BITS-1:0]                  out_second_o,
  output logic [cws_pkg::TYPE_BITS-1:0]            out_type_o
);

  import cws_pkg::*;

  localparam int unsigned END_BITS = TIME_BITS + 1;

  // Queue entry fields
  logic [END_BITS-1:0]     it_end;
  logic [TIME_BITS-1:0]    it_time;
  logic [CRYSTAL_BITS-1:0] it_crystal;
  logic [EVENT_BITS-1:0]   it_event;
  logic                    it_scat;

  phase_e                  phase_q, phase_d;
  logic [TIME_BITS-1:0]    open_time_q;
  logic [END_BITS-1:0]     open_end_q;
  logic [CRYSTAL_BITS-1:0] open_crystal_q;
  logic [EVENT_BITS-1:0]   open_event_q;
  logic                    open_scat_q;
  logic [TIME_BITS-1:0]    part_time_q;
  logic [END_BITS-1:0]     part_end_q;
  logic [CRYSTAL_BITS-1:0] part_crystal_q;
  pair_type_e              part_type_q, part_type_d;
  logic [END_BITS-1:0]     skip_q;

  logic                    out_valid_q, out_valid_d;
  logic [CRYSTAL_BITS-1:0] out_first_q;
  logic [CRYSTAL_BITS-1:0] out_second_q;
  pair_type_e              out_type_q;

  logic [END_BITS-1:0]     t_ext;
  logic                    pop;
  logic                    in_open, part_before, part_after, skip_done;
  logic                    load_open, load_part, skip_open, skip_part, emit;
  logic [64:0]             open_end_new, part_end_new;

  assign {it_scat, it_event, it_crystal, it_time, it_end} = q_data_i;

  assign pop       = q_valid_i && (!out_valid_q || out_ready_i);
  assign q_ready_o = !out_valid_q || out_ready_i;

  // Compare the single against the held window ends
  assign t_ext       = {1'b0, it_time};
  assign in_open     = t_ext < open_end_q;
  assign part_before = t_ext < part_end_q;
  assign part_after  = t_ext > part_end_q;
  assign skip_done   = t_ext >= skip_q;

  // Next pairing state
  always_comb begin
    phase_d = phase_q;
    if (pop) begin
      unique case (phase_q)
        PH_IDLE: phase_d = PH_OPEN;
        PH_OPEN: phase_d = in_open ? PH_PAIR : PH_OPEN;
        PH_PAIR: begin
          priority if (in_open) begin
            phase_d = PH_SKIP;
          end else if (part_after) begin
            phase_d = PH_OPEN;
          end else if (part_before) begin
            phase_d = PH_SKIP;
          end else begin
            phase_d = PH_OPEN;
          end
        end
        PH_SKIP: phase_d = skip_done ? PH_OPEN : PH_SKIP;
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  // Actions taken for the popped single
  always_comb begin
    load_open = 1'b0;
    load_part = 1'b0;
    skip_open = 1'b0;
    skip_part = 1'b0;
    emit      = 1'b0;
    if (pop) begin
      unique case (phase_q)
        PH_IDLE: load_open = 1'b1;
        PH_OPEN: begin
          load_part = in_open;
          load_open = !in_open;
        end
        PH_PAIR: begin
          priority if (in_open) begin
            skip_open = 1'b1;
          end else if (part_after) begin
            emit      = 1'b1;
            load_open = 1'b1;
          end else if (part_before) begin
            skip_part = 1'b1;
          end else begin
            load_open = 1'b1;
          end
        end
        PH_SKIP: load_open = skip_done;
        default: load_open = 1'b0;
      endcase
    end
  end

  // Classify the pair when the partner arrives
  always_comb begin
    if (open_event_q != it_event) begin
      part_type_d = PT_RANDOM;
    end else if (open_scat_q || it_scat) begin
      part_type_d = PT_SCATTER;
    end else begin
      part_type_d = PT_TRUE;
    end
  end

  // Rebuild held window ends when the window changes
  assign open_end_new = window_end(64'(open_time_q), cfg_i.window);
  assign part_end_new = window_end(64'(part_time_q), cfg_i.window);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      out_valid_q <= 1'b0;
      open_time_q <= '0;
      open_end_q  <= '0;
      part_time_q <= '0;
      part_end_q  <= '0;
      skip_q      <= '0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      if (load_open) begin
        open_time_q <= it_time;
        open_end_q  <= it_end;
      end else if (cfg_i.we) begin
        open_end_q  <= open_end_new[END_BITS-1:0];
      end
      if (load_part) begin
        part_time_q <= it_time;
        part_end_q  <= it_end;
      end else if (cfg_i.we) begin
        part_end_q  <= part_end_new[END_BITS-1:0];
      end
      if (skip_open) begin
        skip_q <= open_end_q;
      end else if (skip_part) begin
        skip_q <= part_end_q;
      end
    end
  end

  // Hold opener and partner payload
  always_ff @(posedge clk_i) begin
    if (load_open) begin
      open_crystal_q <= it_crystal;
      open_event_q   <= it_event;
      open_scat_q    <= it_scat;
    end
    if (load_part) begin
      part_crystal_q <= it_crystal;
      part_type_q    <= part_type_d;
    end
    if (emit) begin
      out_first_q  <= open_crystal_q;
      out_second_q <= part_crystal_q;
      out_type_q   <= part_type_q;
    end
  end

  // Output register: set on a coincidence, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_first_o  = out_first_q;
  assign out_second_o = out_second_q;
  assign out_type_o   = out_type_q;

endmodule

`default_nettype wire

>>> sv/coincidence_window_sorter.sv
// Channel   Dir  tdata (low bit up)                          tuser
// s_axis    in   arrival_time, crystal_id, event_id, zeros   scattered
// m_axis    out  first_crystal, second_crystal, zeros        pair_type
// cfg_wr    in   coincidence_window (write enable + data)    -
//
// One single per cycle sustained unless the output stalls; a single is
// queued before pairing; a coincidence is registered as its closing single pops.
// The window end is added in the front and registered in a two-entry queue, so
// the back end only compares against held ends each cycle.
// Reset clears the pairing state to idle and the window to 4000 ticks.
// A stalled output holds its result; the queue keeps accepting until full.
`default_nettype none

module coincidence_window_sorter #(
  parameter int unsigned TIME_BITS    = 48,
  parameter int unsigned CRYSTAL_BITS = 15
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_wr_en_i,
  input  wire logic [cws_pkg::WINDOW_BITS-1:0]   cfg_wr_data_i,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // arrival_time, crystal_id, event_id, zero fill
  input  wire logic [((TIME_BITS+CRYSTAL_BITS+cws_pkg::EVENT_BITS+7)/8)*8-1:0]
                                                 s_axis_tdata,
  // scattered
  input  wire logic [0:0]                        s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // first_crystal, second_crystal, zero fill
  output logic [((2*CRYSTAL_BITS+7)/8)*8-1:0]    m_axis_tdata,
  // pair_type
  output logic [cws_pkg::TYPE_BITS-1:0]          m_axis_tuser
);

  import cws_pkg::*;

  localparam int unsigned IN_BITS    = ((TIME_BITS+CRYSTAL_BITS+EVENT_BITS+7)/8)*8;
  localparam int unsigned OUT_BITS   = ((2*CRYSTAL_BITS+7)/8)*8;
  localparam int unsigned ENTRY_BITS = 2*TIME_BITS + 1 + CRYSTAL_BITS + EVENT_BITS + 1;

  cfg_t                    cfg;
  logic                    fq_valid, fq_ready;
  logic [ENTRY_BITS-1:0]   fq_data;
  logic                    qb_valid, qb_ready;
  logic [ENTRY_BITS-1:0]   qb_data;
  logic [CRYSTAL_BITS-1:0] first_crystal, second_crystal;

  cws_front #(
    .TIME_BITS   (TIME_BITS),
    .CRYSTAL_BITS(CRYSTAL_BITS),
    .TDATA_BITS  (IN_BITS),
    .ENTRY_BITS  (ENTRY_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_wr_en_i  (cfg_wr_en_i),
    .cfg_wr_data_i(cfg_wr_data_i),
    .cfg_o        (cfg),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .s_flag_i     (s_axis_tuser[0]),
    .q_valid_o    (fq_valid),
    .q_ready_i    (fq_ready),
    .q_data_o     (fq_data)
  );

  cws_queue #(
    .WIDTH(ENTRY_BITS)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(fq_valid),
    .push_ready_o(fq_ready),
    .push_data_i (fq_data),
    .pop_valid_o (qb_valid),
    .pop_ready_i (qb_ready),
    .pop_data_o  (qb_data)
  );

  cws_back #(
    .TIME_BITS   (TIME_BITS),
    .CRYSTAL_BITS(CRYSTAL_BITS),
    .ENTRY_BITS  (ENTRY_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (qb_valid),
    .q_ready_o   (qb_ready),
    .q_data_i    (qb_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_first_o (first_crystal),
    .out_second_o(second_crystal),
    .out_type_o  (m_axis_tuser)
  );

  // Pack the result, zero fill on top
  assign m_axis_tdata = OUT_BITS'({second_crystal, first_crystal});

endmodule

`default_nettype wire
